[sv/tgarle_pkg.sv]
// Shared types, codes and colour helpers for the Targa RLE pixel decoder.
// No dependencies; every other file of the block except tgarle_ram refers to this package.
`default_nettype none
package tgarle_pkg;

	// Pixel and colour map formats
	localparam logic [2:0] FMT_GRAY = 3'd0;
	localparam logic [2:0] FMT_15   = 3'd1;
	localparam logic [2:0] FMT_16   = 3'd2;
	localparam logic [2:0] FMT_24   = 3'd3;
	localparam logic [2:0] FMT_32   = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] REG_RLE_ENABLE     = 3'd0;
	localparam logic [2:0] REG_PALETTE_ENABLE = 3'd1;
	localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd2;
	localparam logic [2:0] REG_MAP_FORMAT     = 3'd3;
	localparam logic [2:0] REG_MAP_ENTRIES    = 3'd4;
	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd5;
	localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd6;
	localparam logic [2:0] REG_ROW_ORDER      = 3'd7;

	localparam int unsigned MAP_DEPTH = 256;
	localparam logic [12:0] MAX_DIM   = 13'd4096;

	// Interleave codes in row_order bits 2:1
	localparam logic [1:0] IL_TWO  = 2'd1;
	localparam logic [1:0] IL_FOUR = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic take_byte;
		logic load_colour;
		logic emit_step;
	} tgarle_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pix_done;
		logic use_map;
		logic step_last;
	} tgarle_stat_t;

	// Bytes per item of a format; unknown codes act as 24-bit
	function automatic logic [2:0] fmt_bytes(input logic [2:0] fmt);
		logic [2:0] n;
		case (fmt)
			FMT_GRAY:        n = 3'd1;
			FMT_15, FMT_16:  n = 3'd2;
			FMT_32:          n = 3'd4;
			default:         n = 3'd3;
		endcase
		return n;
	endfunction

	// Little-endian word to RGBA, red in bits 7:0 and alpha in 31:24
	function automatic logic [31:0] decode_colour(input logic [2:0] fmt,
			input logic [31:0] w);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		case (fmt)
			FMT_GRAY: begin
				r = w[7:0]; g = w[7:0]; b = w[7:0]; a = 8'hFF;
			end
			FMT_15, FMT_16: begin
				r = {w[14:10], 3'b000};
				g = {w[9:8], w[7:5], 3'b000};
				b = {w[4:0], 3'b000};
				a = (fmt == FMT_16) ? {8{w[15]}} : 8'hFF;
			end
			FMT_32: begin
				b = w[7:0]; g = w[15:8]; r = w[23:16]; a = w[31:24];
			end
			default: begin
				b = w[7:0]; g = w[15:8]; r = w[23:16]; a = 8'hFF;
			end
		endcase
		return {a, b, g, r};
	endfunction

endpackage
`default_nettype wire

[sv/tgarle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tgarle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[sv/tgarle_ctrl.sv]
// Sequencer of the Targa RLE decoder: byte intake, palette lookup, segment emission.
// Depends on tgarle_pkg for the command and status structs.
`default_nettype none
module tgarle_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire tgarle_pkg::tgarle_stat_t st,
	output tgarle_pkg::tgarle_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Take bytes only while no pixel is being expanded
	assign s_tready        = (state_q == ST_IDLE);
	assign cmd.take_byte   = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.load_colour = (state_q == ST_LOOK);
	assign cmd.emit_step   = (state_q == ST_EMIT);

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && st.pix_done) begin
						state_q <= st.use_map ? ST_LOOK : ST_EMIT;
					end
				end
				ST_LOOK: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (st.step_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/tgarle_dp.sv]
// Datapath of the Targa RLE decoder: registers, byte gathering, colour map, row walk.
// Depends on tgarle_pkg and tgarle_ram.
`default_nettype none
module tgarle_dp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [7:0]              s_tdata,
	input  wire logic                    cfg_valid,
	input  wire logic [2:0]              cfg_index,
	input  wire logic [13:0]             cfg_data,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [63:0]                  m_tdata,
	output logic                         m_tlast,
	input  wire tgarle_pkg::tgarle_cmd_t cmd,
	output tgarle_pkg::tgarle_stat_t     st
);

	typedef enum logic [1:0] {
		PH_MAP,
		PH_HEAD,
		PH_BODY,
		PH_DONE
	} phase_t;

	localparam logic [12:0] MAXD = tgarle_pkg::MAX_DIM;

	// Configuration
	logic        rle_q, pal_q;
	logic [2:0]  pfmt_q, mfmt_q, rord_q;
	logic [13:0] ment_q;
	logic [12:0] wid_q, hgt_q;

	// Decode state
	phase_t      phase_q;
	logic [23:0] hold_q;
	logic [1:0]  bidx_q;
	logic [13:0] mwc_q;
	logic [6:0]  rem_q;
	logic        rep_q;
	logic [12:0] col_q, rows_q, trow_q, base_q;
	logic [7:0]  cnt_q;
	logic        rflag_q;
	logic [31:0] colour_q;

	// Output register
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        out_last_q;

	logic [12:0] eff_w, eff_h;
	logic        in_map, is_head, is_pix, complete;
	phase_t      p_eff;
	logic [2:0]  need;
	logic [31:0] gword;
	logic        ram_we, ram_re;
	logic [7:0]  ram_raddr;
	logic [31:0] ram_rdata, map_colour, pix_colour;

	logic        fin, rows_full, col_full, emitting, stall, out_load;
	logic [12:0] room, col_next, step, tr_inc, rows_inc, dest_full;
	logic [7:0]  seg;
	logic        adv_done, wrap;
	logic [11:0] dest;

	// Clamp the image size
	always_comb begin
		if (wid_q > MAXD) eff_w = MAXD;
		else if (wid_q < 13'd4) eff_w = 13'd4;
		else eff_w = wid_q;
		if (hgt_q > MAXD) eff_h = MAXD;
		else if (hgt_q == 13'd0) eff_h = 13'd1;
		else eff_h = hgt_q;
	end

	// Classify the incoming byte and gather it
	assign in_map  = (phase_q == PH_MAP) && pal_q && (mwc_q < ment_q);
	assign p_eff   = (phase_q == PH_MAP && !in_map) ? PH_HEAD : phase_q;
	assign is_head = !in_map && (p_eff == PH_HEAD) && rle_q;
	assign is_pix  = !in_map && !is_head && (phase_q != PH_DONE);
	assign need    = tgarle_pkg::fmt_bytes(in_map ? mfmt_q : pfmt_q);
	assign gword   = {8'd0, hold_q} | ({24'd0, s_tdata} << {bidx_q, 3'b000});
	assign complete = ({1'b0, bidx_q} + 3'd1) >= need;

	assign map_colour = tgarle_pkg::decode_colour(mfmt_q, gword);
	assign pix_colour = tgarle_pkg::decode_colour(pfmt_q, gword);

	// Colour map
	assign ram_we    = cmd.take_byte && in_map && complete && (mwc_q[13:8] == 6'd0);
	assign ram_re    = cmd.take_byte && is_pix && complete && pal_q;
	assign ram_raddr = (pfmt_q <= tgarle_pkg::FMT_16) ? gword[7:0] : 8'd0;

	tgarle_ram #(
		.WIDTH(32),
		.DEPTH(tgarle_pkg::MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(mwc_q[7:0]),
		.wdata(map_colour),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// One row-walk step per emit cycle, unless a full output register waits on m_tready
	assign fin       = (cnt_q == 8'd0) || (phase_q == PH_DONE);
	assign rows_full = rows_q >= eff_h;
	assign col_full  = col_q >= eff_w;
	assign room      = eff_w - col_q;
	assign seg       = ({5'd0, cnt_q} < room) ? cnt_q : room[7:0];
	assign col_next  = col_q + {5'd0, seg};
	assign emitting  = cmd.emit_step && !fin && !rows_full && !col_full;
	assign stall     = emitting && out_valid_q && !m_tready;
	assign out_load  = emitting && !stall;

	always_comb begin
		if (rord_q[2:1] == tgarle_pkg::IL_FOUR) step = 13'd4;
		else if (rord_q[2:1] == tgarle_pkg::IL_TWO) step = 13'd2;
		else step = 13'd1;
	end
	assign tr_inc    = trow_q + step;
	assign wrap      = tr_inc >= eff_h;
	assign rows_inc  = rows_q + 13'd1;
	assign adv_done  = rows_inc >= eff_h;
	assign dest_full = eff_h - 13'd1 - trow_q;
	assign dest      = rord_q[0] ? trow_q[11:0] : dest_full[11:0];

	assign st.pix_done   = is_pix && complete;
	assign st.use_map    = pal_q;
	assign st.step_last  = fin;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_q  <= 1'b0;
			pal_q  <= 1'b0;
			pfmt_q <= tgarle_pkg::FMT_24;
			mfmt_q <= tgarle_pkg::FMT_24;
			ment_q <= 14'd0;
			wid_q  <= MAXD;
			hgt_q  <= MAXD;
			rord_q <= 3'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tgarle_pkg::REG_RLE_ENABLE:     rle_q  <= cfg_data[0];
				tgarle_pkg::REG_PALETTE_ENABLE: pal_q  <= cfg_data[0];
				tgarle_pkg::REG_PIXEL_FORMAT:   pfmt_q <= cfg_data[2:0];
				tgarle_pkg::REG_MAP_FORMAT:     mfmt_q <= cfg_data[2:0];
				tgarle_pkg::REG_MAP_ENTRIES:    ment_q <= cfg_data;
				tgarle_pkg::REG_IMAGE_WIDTH:    wid_q  <= cfg_data[12:0];
				tgarle_pkg::REG_IMAGE_HEIGHT:   hgt_q  <= cfg_data[12:0];
				tgarle_pkg::REG_ROW_ORDER:      rord_q <= cfg_data[2:0];
			endcase
		end
	end

	// Decode state: byte intake and row walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAP;
			hold_q  <= 24'd0;
			bidx_q  <= 2'd0;
			mwc_q   <= 14'd0;
			rem_q   <= 7'd0;
			rep_q   <= 1'b0;
			col_q   <= 13'd0;
			rows_q  <= 13'd0;
			trow_q  <= 13'd0;
			base_q  <= 13'd0;
			cnt_q   <= 8'd0;
			rflag_q <= 1'b0;
		end else if (cmd.take_byte) begin
			if (in_map) begin
				if (complete) begin
					hold_q <= 24'd0;
					bidx_q <= 2'd0;
					mwc_q  <= mwc_q + 14'd1;
					if ((mwc_q + 14'd1) >= ment_q) phase_q <= PH_HEAD;
				end else begin
					hold_q <= gword[23:0];
					bidx_q <= bidx_q + 2'd1;
				end
			end else if (is_head) begin
				rep_q   <= s_tdata[7];
				rem_q   <= s_tdata[6:0];
				phase_q <= PH_BODY;
				hold_q  <= 24'd0;
				bidx_q  <= 2'd0;
			end else if (is_pix) begin
				phase_q <= p_eff;
				if (complete) begin
					hold_q  <= 24'd0;
					bidx_q  <= 2'd0;
					rflag_q <= (p_eff == PH_BODY) && rep_q;
					cnt_q   <= ((p_eff == PH_BODY) && rep_q) ? ({1'b0, rem_q} + 8'd1) : 8'd1;
				end else begin
					hold_q <= gword[23:0];
					bidx_q <= bidx_q + 2'd1;
				end
			end
		end else if (cmd.emit_step) begin
			priority if (fin) begin
				// Close the packet bookkeeping
				if (phase_q != PH_DONE) begin
					if (rflag_q) begin
						phase_q <= PH_HEAD;
						rem_q   <= 7'd0;
					end else if (phase_q == PH_BODY) begin
						if (rem_q == 7'd0) phase_q <= PH_HEAD;
						else rem_q <= rem_q - 7'd1;
					end
				end else if (rflag_q) begin
					rem_q <= 7'd0;
				end
			end else if (rows_full) begin
				phase_q <= PH_DONE;
			end else if (col_full || !stall) begin
				if (!col_full) begin
					cnt_q <= cnt_q - seg;
				end
				// Move to the next row once this one is full
				if (col_full || col_next >= eff_w) begin
					col_q  <= 13'd0;
					rows_q <= rows_inc;
					if (wrap) begin
						base_q <= base_q + 13'd1;
						trow_q <= base_q + 13'd1;
					end else begin
						trow_q <= tr_inc;
					end
					if (adv_done) phase_q <= PH_DONE;
				end else begin
					col_q <= col_next;
				end
			end
		end
	end

	// Segment colour
	always_ff @(posedge clk) begin
		if (cmd.take_byte && is_pix && complete && !pal_q) begin
			colour_q <= pix_colour;
		end else if (cmd.load_colour) begin
			colour_q <= ram_rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {seg, col_q[11:0], dest, colour_q};
			out_last_q <= (col_next >= eff_w) && adv_done;
		end
	end

endmodule
`default_nettype wire

[sv/tga_rle_pixel_decoder_unit.sv]
// Top level of the Targa RLE pixel decoder: controller, datapath and assertions.
// Depends on tgarle_pkg, tgarle_ctrl, tgarle_dp and tgarle_ram.
`default_nettype none
// Decodes the body of a Targa image (colour map, then raw or run-length pixels) arriving
// one byte per transaction into RGBA row segments. A byte that completes a pixel is then
// expanded into segments (after a colour map read in palette mode, with a further step
// when a register change left the column at or past the row end, and with a new segment
// waiting on m_tready); the input is held off while a pixel is expanded, since segments
// leave one per cycle, while m_tready allows, through a single output register. The user
// must write configuration only while idle; the block does not enforce it. m_tlast marks
// the segment that holds the final pixel; bytes after the image are taken and dropped.
module tga_rle_pixel_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// red[7:0], green[15:8], blue[23:16], alpha[31:24], dest_row[43:32],
	// first_column[55:44], span_length[63:56]
	output logic      [63:0] m_tdata,
	output logic             m_tlast,   // image_done
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [13:0] cfg_data
);

	tgarle_pkg::tgarle_cmd_t  cmd;
	tgarle_pkg::tgarle_stat_t st;

	assign cfg_ready = 1'b1;

	tgarle_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	tgarle_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.st       (st)
	);

	// A segment is never empty
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:56] != 8'd0))
		else $error("empty segment");

	// A segment stays inside the row
	a_span_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (({1'b0, m_tdata[55:44]} + {5'd0, m_tdata[63:56]}) <= 13'd4096))
		else $error("segment past row end");

	// New segments come only while byte intake is held off
	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("segment emitted while taking bytes");

	// Byte intake, colour loads and emission steps never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take_byte, cmd.load_colour, cmd.emit_step}))
		else $error("overlapping datapath commands");

endmodule
`default_nettype wire
